// ----- sv/qdw_pkg.sv -----
// Shared types, constants and arithmetic helpers for the drag wrench unit.
`timescale 1ns / 1ps
`default_nettype none
package qdw_pkg;

  localparam int IN_W    = 16;
  localparam int MAT_W   = 34;
  localparam int PROD_W  = MAT_W + IN_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ROT_W   = 22;
  localparam int SQ_W    = 2 * ROT_W;
  localparam int SQRT_W  = SQ_W / 2;
  localparam int REM_W   = SQRT_W + 3;
  localparam int CN_W    = IN_W + SQRT_W;
  localparam int P_W     = CN_W + 1 + ROT_W;
  localparam int DRAG_W  = P_W - 20;
  localparam int OUT_W   = 32;
  localparam int LANE_LAT = 4 + SQRT_W + 3;
  localparam int R_DLY   = 2 + SQRT_W;

  typedef logic signed [IN_W-1:0]   vel_t;
  typedef logic signed [MAT_W-1:0]  mat_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [DRAG_W-1:0] drag_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  typedef enum logic [2:0] {
    CFG_LIN_XY = 3'd0,
    CFG_LIN_Z  = 3'd1,
    CFG_ROT_XY = 3'd2,
    CFG_ROT_Z  = 3'd3,
    CFG_WIND_X = 3'd4,
    CFG_WIND_Y = 3'd5,
    CFG_WIND_Z = 3'd6
  } cfg_idx_e;

  localparam logic signed [MAT_W-1:0] ONE_Q28 = MAT_W'(64'sd268435456);
  localparam logic signed [17:0] CLAMP_HI = 18'sd25600;
  localparam logic signed [17:0] CLAMP_LO = -18'sd25600;

  function automatic vel_t clamp_q88(input logic signed [17:0] v);
    vel_t r;
    if (v > CLAMP_HI) begin
      r = IN_W'(CLAMP_HI);
    end else if (v < CLAMP_LO) begin
      r = IN_W'(CLAMP_LO);
    end else begin
      r = IN_W'(v);
    end
    return r;
  endfunction

  // Diagonal entry: one minus twice the sum of two squares.
  function automatic mat_t mat_diag(input logic signed [31:0] a, input logic signed [31:0] b);
    mat_t s;
    s = MAT_W'(a) + MAT_W'(b);
    return ONE_Q28 - (s <<< 1);
  endfunction

  // Off-diagonal entry: twice the sum or difference of two products.
  function automatic mat_t mat_off(input logic signed [31:0] a, input logic signed [31:0] b,
                                   input logic sub);
    mat_t s;
    s = sub ? (MAT_W'(a) - MAT_W'(b)) : (MAT_W'(a) + MAT_W'(b));
    return s <<< 1;
  endfunction

  function automatic out_t sat_out(input drag_t d, input logic neg);
    logic signed [DRAG_W:0] v;
    out_t r;
    v = neg ? -((DRAG_W+1)'(d)) : (DRAG_W+1)'(d);
    if (v > (DRAG_W+1)'(64'sd2147483647)) begin
      r = out_t'(32'h7FFF_FFFF);
    end else if (v < (DRAG_W+1)'(-64'sd2147483648)) begin
      r = out_t'(32'h8000_0000);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/quadrotor_drag_wrench_unit.sv -----
// An accepted word passes the input registers, the two lanes and the merge register to done_o.
// Throughput: one word per cycle; busy_o stays low, the pipeline never stalls.
// The depth is set by the 22-stage square root in each of the two lanes.
// Reset clears the configuration registers and all valid flags; no clearing pass.
// Results are shown for one cycle on done_o and the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module quadrotor_drag_wrench_unit
  import qdw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire vel_t        vel_x_i,
  input  wire vel_t        vel_y_i,
  input  wire vel_t        vel_z_i,
  input  wire vel_t        rate_x_i,
  input  wire vel_t        rate_y_i,
  input  wire vel_t        rate_z_i,
  input  wire vel_t        quat_w_i,
  input  wire vel_t        quat_x_i,
  input  wire vel_t        quat_y_i,
  input  wire vel_t        quat_z_i,
  output logic             done_o,
  output out_t             force_x_o,
  output out_t             force_y_o,
  output out_t             force_z_o,
  output out_t             torque_x_o,
  output out_t             torque_y_o,
  output out_t             torque_z_o
);

  logic [IN_W-1:0] lin_xy_q, lin_z_q, rot_xy_q, rot_z_q;
  vel_t            wind_x_q, wind_y_q, wind_z_q;

  logic va_q, vb_q;
  vel_t ua_q [6];
  vel_t ub_q [6];
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  mat_t m_q [3][3];
  vel_t ua_d [6];

  logic  lin_vld, ang_vld;
  drag_t lin_drag [3];
  drag_t ang_drag [3];
  out_t  force_v [3];
  out_t  torque_v [3];
  vel_t  ul [3];
  vel_t  ur [3];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_xy_q <= '0;
      lin_z_q  <= '0;
      rot_xy_q <= '0;
      rot_z_q  <= '0;
      wind_x_q <= '0;
      wind_y_q <= '0;
      wind_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIN_XY: lin_xy_q <= cfg_wdata_i;
        CFG_LIN_Z:  lin_z_q  <= cfg_wdata_i;
        CFG_ROT_XY: rot_xy_q <= cfg_wdata_i;
        CFG_ROT_Z:  rot_z_q  <= cfg_wdata_i;
        CFG_WIND_X: wind_x_q <= cfg_wdata_i;
        CFG_WIND_Y: wind_y_q <= cfg_wdata_i;
        CFG_WIND_Z: wind_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Air-relative velocity and body rate, with y and z flipped and clamped to 100.
  always_comb begin
    ua_d[0] = clamp_q88(18'(vel_x_i) - 18'(wind_x_q));
    ua_d[1] = clamp_q88(-(18'(vel_y_i) - 18'(wind_y_q)));
    ua_d[2] = clamp_q88(-(18'(vel_z_i) - 18'(wind_z_q)));
    ua_d[3] = clamp_q88(18'(rate_x_i));
    ua_d[4] = clamp_q88(-18'(rate_y_i));
    ua_d[5] = clamp_q88(-18'(rate_z_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= start_i && !busy_o;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q <= ua_d;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    xz_q <= quat_x_i * quat_z_i;
    yz_q <= quat_y_i * quat_z_i;
    wx_q <= quat_w_i * quat_x_i;
    wy_q <= quat_w_i * quat_y_i;
    wz_q <= quat_w_i * quat_z_i;

    ub_q    <= ua_q;
    m_q[0][0] <= mat_diag(yy_q, zz_q);
    m_q[0][1] <= mat_off(xy_q, wz_q, 1'b1);
    m_q[0][2] <= mat_off(xz_q, wy_q, 1'b0);
    m_q[1][0] <= mat_off(xy_q, wz_q, 1'b0);
    m_q[1][1] <= mat_diag(xx_q, zz_q);
    m_q[1][2] <= mat_off(yz_q, wx_q, 1'b1);
    m_q[2][0] <= mat_off(xz_q, wy_q, 1'b1);
    m_q[2][1] <= mat_off(yz_q, wx_q, 1'b0);
    m_q[2][2] <= mat_diag(xx_q, yy_q);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ul[i] = ub_q[i];
      ur[i] = ub_q[i+3];
    end
  end

  qdw_lane u_lane_lin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vb_q),
    .m_i       (m_q),
    .u_i       (ul),
    .coef_xy_i (lin_xy_q),
    .coef_z_i  (lin_z_q),
    .valid_o   (lin_vld),
    .drag_o    (lin_drag)
  );

  qdw_lane u_lane_ang (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vb_q),
    .m_i       (m_q),
    .u_i       (ur),
    .coef_xy_i (rot_xy_q),
    .coef_z_i  (rot_z_q),
    .valid_o   (ang_vld),
    .drag_o    (ang_drag)
  );

  qdw_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (lin_vld && ang_vld),
    .lin_i    (lin_drag),
    .ang_i    (ang_drag),
    .done_o   (done_o),
    .force_o  (force_v),
    .torque_o (torque_v)
  );

  assign force_x_o  = force_v[0];
  assign force_y_o  = force_v[1];
  assign force_z_o  = force_v[2];
  assign torque_x_o = torque_v[0];
  assign torque_y_o = torque_v[1];
  assign torque_z_o = torque_v[2];

endmodule
`default_nettype wire

// ----- sv/qdw_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qdw_isqrt
  import qdw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [SQ_W-1:0]   x_i,
  output logic      [SQRT_W-1:0] root_o
);

  logic [REM_W-1:0]  rem_q  [SQRT_W];
  logic [SQRT_W-1:0] root_q [SQRT_W];
  logic [SQ_W-1:0]   x_q    [SQRT_W];

  for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_d;
    logic [SQRT_W-1:0] root_in, root_d;
    logic [SQ_W-1:0]   x_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], x_in[SQ_W-1-2*k -: 2]};
      trial  = (REM_W'(root_in) << 2) | REM_W'(1);
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[SQRT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[SQRT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      x_q[k]    <= x_in;
    end
  end

  assign root_o = root_q[SQRT_W-1];

endmodule
`default_nettype wire

// ----- sv/qdw_lane.sv -----
// One drag lane: rotation, Euclidean norm and per-axis quadratic drag of a vector.
`timescale 1ns / 1ps
`default_nettype none
module qdw_lane
  import qdw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire mat_t               m_i [3][3],
  input  wire vel_t               u_i [3],
  input  wire logic [IN_W-1:0]    coef_xy_i,
  input  wire logic [IN_W-1:0]    coef_z_i,
  output logic                    valid_o,
  output drag_t                   drag_o [3]
);

  logic [LANE_LAT-1:0] vld_q;

  logic signed [PROD_W-1:0] prod_q [3][3];
  rot_t                     r_q    [3];
  logic signed [SQ_W-1:0]   sq_q   [3];
  logic        [SQ_W-1:0]   sumsq_q;
  rot_t                     r_dl_q [R_DLY][3];
  logic        [SQRT_W-1:0] root;
  logic        [CN_W-1:0]   cn_q   [3];
  rot_t                     r_d1_q [3];
  logic signed [P_W-1:0]    p_q    [3];
  drag_t                    drag_q [3];

  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [SUM_W-1:0]  sum_d  [3];
  logic signed [SQ_W-1:0]   sq_d   [3];
  logic signed [P_W-1:0]    p_d    [3];
  logic signed [P_W-1:0]    pr_d   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LANE_LAT-2:0], valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = m_i[i][j] * u_i[j];
      end
      sum_d[i] = SUM_W'(prod_q[i][0]) + SUM_W'(prod_q[i][1]) + SUM_W'(prod_q[i][2])
               + SUM_W'(64'sd134217728);
      sq_d[i]  = r_q[i] * r_q[i];
      p_d[i]   = $signed({1'b0, cn_q[i]}) * r_d1_q[i];
      pr_d[i]  = p_q[i] + P_W'(64'sd524288);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= prod_d[i][j];
      end
      r_q[i]       <= sum_d[i][28 +: ROT_W];
      sq_q[i]      <= sq_d[i];
      r_dl_q[0][i] <= r_q[i];
      for (int k = 1; k < R_DLY; k++) begin
        r_dl_q[k][i] <= r_dl_q[k-1][i];
      end
      cn_q[i]   <= ((i < 2) ? coef_xy_i : coef_z_i) * root;
      r_d1_q[i] <= r_dl_q[R_DLY-1][i];
      p_q[i]    <= p_d[i];
      drag_q[i] <= pr_d[i][P_W-1:20];
    end
    sumsq_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  qdw_isqrt u_isqrt (
    .clk_i  (clk_i),
    .x_i    (sumsq_q),
    .root_o (root)
  );

  assign valid_o = vld_q[LANE_LAT-1];
  assign drag_o  = drag_q;

endmodule
`default_nettype wire

// ----- sv/qdw_merge.sv -----
// Merging stage: applies the output sign convention and saturates the wrench.
`timescale 1ns / 1ps
`default_nettype none
module qdw_merge
  import qdw_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire drag_t lin_i [3],
  input  wire drag_t ang_i [3],
  output logic       done_o,
  output out_t       force_o [3],
  output out_t       torque_o [3]
);

  logic done_q;
  out_t force_q [3];
  out_t torque_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // The x axis is reported negated, y and z as they are.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      force_q[i]  <= sat_out(lin_i[i], i == 0);
      torque_q[i] <= sat_out(ang_i[i], i == 0);
    end
  end

  assign done_o   = done_q;
  assign force_o  = force_q;
  assign torque_o = torque_q;

endmodule
`default_nettype wire

// ----- sv/qdw_checker.sv -----
// Port-level checker for the drag wrench unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qdw_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o
);

  // Every accepted word yields its result on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##32 done_o)
    else $error("accepted word produced no result after 32 cycles");

  // No result appears without an earlier accepted word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 32))
    else $error("result without a matching accepted word");

  // The pipeline never refuses a word.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("busy raised although the pipeline cannot stall");

endmodule

bind quadrotor_drag_wrench_unit qdw_checker u_qdw_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
`default_nettype wire
